FILE: rtl/core/pctr_pkg.sv
`default_nettype none

package pctr_pkg;

   localparam int IDX_W   = 8;
   localparam int COUNT_W = 9;

   // command codes
   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_ANALYZE = 2'd1;
   localparam logic [1:0] CMD_CONVERT = 2'd2;

   // output format codes
   localparam logic [2:0] FMT_PALETTE    = 3'd0;
   localparam logic [2:0] FMT_GRAY       = 3'd1;
   localparam logic [2:0] FMT_GRAY_ALPHA = 3'd2;
   localparam logic [2:0] FMT_RGB        = 3'd3;
   localparam logic [2:0] FMT_RGBA       = 3'd4;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } req_type;

   typedef struct packed {
      logic [2:0]         format;
      logic               palette_usable;
      logic               gray_only;
      logic               opaque_only;
      logic               new_entry;
      logic [IDX_W-1:0]   entry_index;
      logic [COUNT_W-1:0] palette_count;
      logic               lookup_miss;
      logic [31:0]        out_bytes;
      logic [2:0]         byte_count;
   } rsp_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] hit_index;
   } probe_type;

   // append write broadcast to the row
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] index;
      logic [31:0]      data;
   } wr_type;

   function automatic logic [2:0] pick_format(input logic pal, input logic gray,
                                              input logic opaque);
      logic [2:0] fmt;
      if (pal)                fmt = FMT_PALETTE;
      else if (gray && opaque) fmt = FMT_GRAY;
      else if (gray)          fmt = FMT_GRAY_ALPHA;
      else if (opaque)        fmt = FMT_RGB;
      else                    fmt = FMT_RGBA;
      return fmt;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pctr_cell.sv
`default_nettype none

module pctr_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire [31:0]                  color,
   input  wire [pctr_pkg::COUNT_W-1:0] live_count,
   input  pctr_pkg::wr_type            wr,
   input  pctr_pkg::probe_type         probe_in,
   output pctr_pkg::probe_type         probe_out
);
   import pctr_pkg::*;

   localparam logic [IDX_W-1:0]   MY_INDEX = IDX_W'(CELL_INDEX);
   localparam logic [COUNT_W-1:0] MY_SLOT  = COUNT_W'(CELL_INDEX);

   logic [31:0] entry_ff;
   probe_type   probe_ff;
   probe_type   probe_in_next;
   logic        match;

   // only entries below the fill count take part
   assign match = (MY_SLOT < live_count) && (entry_ff == color);

   always_comb begin
      probe_in_next = probe_in;
      if (!probe_in.hit && match) begin
         probe_in_next.hit       = 1'b1;
         probe_in_next.hit_index = MY_INDEX;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.index == MY_INDEX) begin
         entry_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_next;
      end
   end

   assign probe_out = probe_ff;

endmodule

`default_nettype wire

FILE: rtl/core/png_color_type_reducer_core.sv
`default_nettype none

// Clear, unused commands and pixels that skip the search (palette given up) pass
//   through the finish state to their result strobe; palette searches (analyze or
//   convert while usable) walk a token down PALETTE_SIZE cells before the result.
// A transfer is taken only while idle, so a new pixel waits until the last is done;
//   busy stays high until the result strobe goes out. The receiver cannot stall.
// Reset (synchronous): flags to one, palette count to zero; cell contents are ignored.
module png_color_type_reducer_core #(
   parameter int PALETTE_SIZE = 256
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  pctr_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output pctr_pkg::rsp_type  rsp_data
);
   import pctr_pkg::*;

   localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
   localparam logic [CNT_W-1:0]   SEARCH_LAST = CNT_W'(PALETTE_SIZE);
   localparam logic [COUNT_W-1:0] PAL_LIMIT   = COUNT_W'(PALETTE_SIZE);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               gray_ff, gray_in;
   logic               opaque_ff, opaque_in;
   logic               pal_ff, pal_in;
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff, rsp_in;
   wr_type             wr;

   logic        accept;
   logic        finish;
   logic        need_search;
   logic [31:0] packed_color;
   logic [2:0]  cur_fmt;
   probe_type   chain [0:PALETTE_SIZE];

   assign accept       = start && (state_ff == ST_IDLE);
   assign packed_color = {req_ff.red, req_ff.green, req_ff.blue, req_ff.alpha};
   assign cur_fmt      = pick_format(pal_ff, gray_ff, opaque_ff);

   // a search is needed whenever the palette is still usable and the pixel
   // is analyzed or converted (usable palette means palette format)
   assign need_search = pal_ff &&
                        (req_data.cmd == CMD_ANALYZE || req_data.cmd == CMD_CONVERT);

   assign finish = (state_ff == ST_FINISH) ||
                   (state_ff == ST_SEARCH && cnt_ff == SEARCH_LAST);

   // ---------------------------------------------------------------
   // Row of palette cells; the head gets a fresh empty token each cycle.
   // Color and count stay put for the whole search, so the token at the
   // tail is valid once it has passed every cell.
   // ---------------------------------------------------------------
   assign chain[0] = '0;

   for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
      pctr_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .color      (packed_color),
         .live_count (count_ff),
         .wr         (wr),
         .probe_in   (chain[i]),
         .probe_out  (chain[i+1])
      );
   end

   // ---------------------------------------------------------------
   // Next-state and result logic
   // ---------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      cnt_in    = cnt_ff;
      count_in  = count_ff;
      gray_in   = gray_ff;
      opaque_in = opaque_ff;
      pal_in    = pal_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      wr        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               cnt_in   = '0;
               state_in = need_search ? ST_SEARCH : ST_FINISH;
            end
         end
         ST_SEARCH: begin
            cnt_in = cnt_ff + 1'b1;
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         strobe_in = 1'b1;
         rsp_in    = '0;
         case (req_ff.cmd)
            CMD_CLEAR: begin
               count_in  = '0;
               gray_in   = 1'b1;
               opaque_in = 1'b1;
               pal_in    = 1'b1;
            end
            CMD_ANALYZE: begin
               if (req_ff.red != req_ff.green || req_ff.green != req_ff.blue) begin
                  gray_in = 1'b0;
               end
               if (req_ff.alpha != ALPHA_OPAQUE) begin
                  opaque_in = 1'b0;
               end
               if (pal_ff) begin
                  if (chain[PALETTE_SIZE].hit) begin
                     rsp_in.entry_index = chain[PALETTE_SIZE].hit_index;
                  end else if (count_ff >= PAL_LIMIT) begin
                     pal_in = 1'b0;
                  end else begin
                     // append at the fill count
                     wr.en              = 1'b1;
                     wr.index           = count_ff[IDX_W-1:0];
                     wr.data            = packed_color;
                     count_in           = count_ff + 1'b1;
                     rsp_in.new_entry   = 1'b1;
                     rsp_in.entry_index = count_ff[IDX_W-1:0];
                  end
               end
            end
            CMD_CONVERT: begin
               case (cur_fmt)
                  FMT_PALETTE: begin
                     rsp_in.byte_count = 3'd1;
                     if (chain[PALETTE_SIZE].hit) begin
                        rsp_in.entry_index = chain[PALETTE_SIZE].hit_index;
                        rsp_in.out_bytes   = {chain[PALETTE_SIZE].hit_index, 24'd0};
                     end else begin
                        rsp_in.lookup_miss = 1'b1;
                     end
                  end
                  FMT_GRAY: begin
                     rsp_in.out_bytes  = {req_ff.red, 24'd0};
                     rsp_in.byte_count = 3'd1;
                  end
                  FMT_GRAY_ALPHA: begin
                     rsp_in.out_bytes  = {req_ff.red, req_ff.alpha, 16'd0};
                     rsp_in.byte_count = 3'd2;
                  end
                  FMT_RGB: begin
                     rsp_in.out_bytes  = {req_ff.red, req_ff.green, req_ff.blue, 8'd0};
                     rsp_in.byte_count = 3'd3;
                  end
                  default: begin
                     rsp_in.out_bytes  = packed_color;
                     rsp_in.byte_count = 3'd4;
                  end
               endcase
            end
            default: begin
               // unused command: state untouched
            end
         endcase
         rsp_in.format         = pick_format(pal_in, gray_in, opaque_in);
         rsp_in.palette_usable = pal_in;
         rsp_in.gray_only      = gray_in;
         rsp_in.opaque_only    = opaque_in;
         rsp_in.palette_count  = count_in;
      end
   end

   // ---------------------------------------------------------------
   // State and registered outputs
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         count_ff  <= '0;
         gray_ff   <= 1'b1;
         opaque_ff <= 1'b1;
         pal_ff    <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         count_ff  <= count_in;
         gray_ff   <= gray_in;
         opaque_ff <= opaque_in;
         pal_ff    <= pal_in;
         strobe_ff <= strobe_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe held two cycles");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after transfer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PAL_LIMIT)
      else $error("palette count past limit");

   a_new_needs_palette: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && rsp_ff.new_entry |-> rsp_ff.palette_usable)
      else $error("new entry with palette given up");

   a_miss_palette_fmt: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && rsp_ff.lookup_miss |->
         rsp_ff.format == FMT_PALETTE && rsp_ff.byte_count == 3'd1)
      else $error("lookup miss outside palette format");

endmodule

`default_nettype wire

FILE: bench/tb_png_color_type_reducer_core.sv
`timescale 1ns / 100ps

module tb_png_color_type_reducer_core;
   import pctr_pkg::*;

   localparam int PAL_SIZE    = 256;
   localparam int LONG_GAP    = PAL_SIZE + 8;      // long enough to land past a full search
   localparam int DRAIN_WAIT  = PAL_SIZE + 4;      // search latency plus margin
   localparam int CYCLE_LIMIT = 3_000_000;         // several times the slowest legal run

   // cmd 3 has no meaning; the block must ignore it
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // color families used to steer the flags
   typedef enum int {PIX_GRAY_OPAQUE, PIX_GRAY_ALPHA, PIX_RGB, PIX_RGBA} pix_kind_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   png_color_type_reducer_core #(
      .PALETTE_SIZE (PAL_SIZE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Shadow of the reducer state: palette contents, entry count and the three
   // image-wide flags. Updated once per accepted transfer, in transfer order.
   // ---------------------------------------------------------------------------
   logic [31:0] held_colors [PAL_SIZE];
   int          held_count  = 0;
   logic        img_gray    = 1'b1;
   logic        img_opaque  = 1'b1;
   logic        palette_ok  = 1'b1;

   rsp_type     reduced_q [$];    // results owed by the block, oldest first

   int mismatches  = 0;
   int n_sent      = 0;
   int n_checked   = 0;
   int n_appends   = 0;
   int n_misses    = 0;
   int n_overflows = 0;
   int cycles      = 0;
   int burst_left  = 0;

   function automatic int find_held(input logic [31:0] color);
      for (int i = 0; i < held_count; i++)
         if (held_colors[i] == color) return i;
      return -1;
   endfunction

   // palette wins while it lasts, then the narrowest direct format
   function automatic logic [2:0] cur_format();
      if (palette_ok)                return FMT_PALETTE;
      if (img_gray && img_opaque)    return FMT_GRAY;
      if (img_gray)                  return FMT_GRAY_ALPHA;
      if (img_opaque)                return FMT_RGB;
      return FMT_RGBA;
   endfunction

   // Applies one pixel command to the shadow state, returns the result it owes.
   function automatic rsp_type reduce_pixel(input req_type px);
      rsp_type     r;
      logic [31:0] color;
      int          hit;
      r     = '0;
      color = {px.red, px.green, px.blue, px.alpha};
      case (px.cmd)
         CMD_CLEAR: begin
            held_count = 0;
            img_gray   = 1'b1;
            img_opaque = 1'b1;
            palette_ok = 1'b1;
         end
         CMD_ANALYZE: begin
            if (px.red != px.green || px.green != px.blue) img_gray = 1'b0;
            if (px.alpha != ALPHA_OPAQUE) img_opaque = 1'b0;
            // once the palette is given up no search happens
            if (palette_ok) begin
               hit = find_held(color);
               if (hit >= 0) begin
                  r.entry_index = hit[7:0];
               end else if (held_count >= PAL_SIZE) begin
                  // one color too many: palette dropped until the next clear
                  palette_ok = 1'b0;
                  n_overflows++;
               end else begin
                  r.entry_index = held_count[7:0];
                  r.new_entry   = 1'b1;
                  held_colors[held_count] = color;
                  held_count++;
                  n_appends++;
               end
            end
         end
         CMD_CONVERT: begin
            case (cur_format())
               FMT_PALETTE: begin
                  r.byte_count = 3'd1;
                  hit = find_held(color);
                  if (hit >= 0) begin
                     r.entry_index = hit[7:0];
                     r.out_bytes   = {hit[7:0], 24'h0};
                  end else begin
                     r.lookup_miss = 1'b1;
                     n_misses++;
                  end
               end
               FMT_GRAY: begin
                  r.out_bytes  = {px.red, 24'h0};
                  r.byte_count = 3'd1;
               end
               FMT_GRAY_ALPHA: begin
                  r.out_bytes  = {px.red, px.alpha, 16'h0};
                  r.byte_count = 3'd2;
               end
               FMT_RGB: begin
                  r.out_bytes  = {px.red, px.green, px.blue, 8'h0};
                  r.byte_count = 3'd3;
               end
               default: begin
                  r.out_bytes  = color;
                  r.byte_count = 3'd4;
               end
            endcase
         end
         default: ;   // unused command: flags only
      endcase
      r.format         = cur_format();
      r.palette_usable = palette_ok;
      r.gray_only      = img_gray;
      r.opaque_only    = img_opaque;
      r.palette_count  = held_count[8:0];
      return r;
   endfunction

   function automatic logic [31:0] kind_color(input pix_kind_type kind);
      logic [7:0]  v;
      logic [7:0]  a;
      logic [31:0] any;
      v   = 8'($urandom);
      a   = 8'($urandom);
      any = $urandom;
      case (kind)
         PIX_GRAY_OPAQUE: return {v, v, v, ALPHA_OPAQUE};
         PIX_GRAY_ALPHA:  return {v, v, v, a};
         PIX_RGB:         return {any[31:8], ALPHA_OPAQUE};
         default:         return any;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Sender. Works in bursts; between bursts start drops for a random gap,
   // now and then longer than a whole palette search so gaps hit every phase.
   // A transfer is the rising edge with start high and busy low.
   // ---------------------------------------------------------------------------
   task automatic send_pixel(input logic [1:0] cmd, input logic [31:0] color);
      req_type px;
      int      gap;
      px.cmd = cmd;
      {px.red, px.green, px.blue, px.alpha} = color;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 15) == 0) ? $urandom_range(1, LONG_GAP)
                                            : $urandom_range(0, 4);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      reduced_q.insert(reduced_q.size(), reduce_pixel(px));
      n_sent++;
   endtask

   // hold off until every owed result is back; always waits on the clock before the first check
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (reduced_q.size() != 0);
   endtask

   // ---------------------------------------------------------------------------
   // Result checker. The receiver cannot stall, so every strobe is a transfer.
   // ---------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (reduced_q.size() == 0) begin
            $error("result with nothing pending: %h", rsp_data);
            mismatches++;
         end else begin
            want = reduced_q.pop_front();
            n_checked++;
            check_field("format",         32'(want.format),        32'(rsp_data.format));
            check_field("palette_usable", 32'(want.palette_usable),
                        32'(rsp_data.palette_usable));
            check_field("gray_only",      32'(want.gray_only),     32'(rsp_data.gray_only));
            check_field("opaque_only",    32'(want.opaque_only),   32'(rsp_data.opaque_only));
            check_field("new_entry",      32'(want.new_entry),     32'(rsp_data.new_entry));
            check_field("entry_index",    32'(want.entry_index),   32'(rsp_data.entry_index));
            check_field("palette_count",  32'(want.palette_count),
                        32'(rsp_data.palette_count));
            check_field("lookup_miss",    32'(want.lookup_miss),   32'(rsp_data.lookup_miss));
            check_field("out_bytes",      want.out_bytes,          rsp_data.out_bytes);
            check_field("byte_count",     32'(want.byte_count),    32'(rsp_data.byte_count));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, reduced_q.size());
         $display("tb_png_color_type_reducer_core: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Field extremes, hits, appends, misses on an empty and a cleared palette,
   // the unused command, and a clear in mid image.
   task automatic test_directed();
      send_pixel(CMD_CLEAR,   32'hFFFF_FFFF);
      send_pixel(CMD_CONVERT, 32'h0000_0000);   // empty palette: miss
      send_pixel(CMD_ANALYZE, 32'h0000_00FF);   // append at 0
      send_pixel(CMD_ANALYZE, 32'h0000_00FF);   // already held
      send_pixel(CMD_ANALYZE, 32'hFFFF_FFFF);   // append at 1
      send_pixel(CMD_CONVERT, 32'hFFFF_FFFF);
      send_pixel(CMD_CONVERT, 32'h0000_00FF);
      send_pixel(CMD_UNUSED,  32'hFFFF_FFFF);
      send_pixel(CMD_ANALYZE, 32'h8080_8000);   // gray, transparent
      send_pixel(CMD_ANALYZE, 32'hFF00_807F);   // not gray
      send_pixel(CMD_CONVERT, 32'hFF00_807F);
      send_pixel(CMD_CONVERT, 32'h1234_5678);   // miss
      send_pixel(CMD_ANALYZE, 32'h0000_00FF);
      send_pixel(CMD_UNUSED,  32'h0000_0000);
      send_pixel(CMD_CLEAR,   32'h0000_0000);
      send_pixel(CMD_CONVERT, 32'h0000_00FF);   // count back at zero: miss
      send_pixel(CMD_ANALYZE, 32'h0102_0304);
      send_pixel(CMD_CONVERT, 32'h0102_0304);
      send_pixel(CMD_ANALYZE, 32'hFEFE_FEFE);
      send_pixel(CMD_CLEAR,   32'hA5A5_A5A5);
   endtask

   // Short images over a small color pool: mostly hits, some misses, noise.
   task automatic test_small_images();
      pix_kind_type kind;
      logic [31:0]  pool [$];
      int           n_pool;
      for (int img = 0; img < 10; img++) begin
         kind = pix_kind_type'($urandom_range(0, 3));
         pool.delete();
         n_pool = $urandom_range(1, 10);
         repeat (n_pool) pool.insert(pool.size(), kind_color(kind));
         // now and then keep going on the previous image
         if ($urandom_range(0, 5) != 0) send_pixel(CMD_CLEAR, $urandom);
         repeat ($urandom_range(2, 15)) begin
            if ($urandom_range(0, 19) == 0) send_pixel(CMD_UNUSED, $urandom);
            send_pixel(CMD_ANALYZE, pool[$urandom_range(0, n_pool - 1)]);
         end
         repeat ($urandom_range(2, 10)) begin
            if ($urandom_range(0, 3) == 0) send_pixel(CMD_CONVERT, $urandom);
            else send_pixel(CMD_CONVERT, pool[$urandom_range(0, n_pool - 1)]);
         end
         if (img == 4) drain_results();   // sender waits out the pipe once mid test
      end
   endtask

   // Fill the palette to its last entry, probe it while full, then push one
   // distinct color past the end and run the direct formats.
   task automatic test_palette_overflow();
      pix_kind_type flood_kinds [3];
      logic [31:0]  color;
      bit           probed;
      flood_kinds = '{PIX_GRAY_ALPHA, PIX_RGB, PIX_RGBA};
      foreach (flood_kinds[k]) begin
         send_pixel(CMD_CLEAR, $urandom);
         probed = 1'b0;
         while (palette_ok) begin
            if (held_count == PAL_SIZE && !probed) begin
               probed = 1'b1;
               send_pixel(CMD_CONVERT, held_colors[$urandom_range(0, PAL_SIZE - 1)]);
               send_pixel(CMD_CONVERT, kind_color(PIX_RGBA));
            end
            if (held_count != 0 && $urandom_range(0, 9) == 0)
               color = held_colors[$urandom_range(0, held_count - 1)];
            else
               color = kind_color(flood_kinds[k]);
            send_pixel(CMD_ANALYZE, color);
         end
         // palette gone: no searches from here, flags may still fall
         repeat (40) begin
            case ($urandom_range(0, 9))
               0:       send_pixel(CMD_ANALYZE, kind_color(PIX_RGBA));
               1, 2:    send_pixel(CMD_ANALYZE, kind_color(flood_kinds[k]));
               3:       send_pixel(CMD_UNUSED, $urandom);
               default: send_pixel(CMD_CONVERT, $urandom);
            endcase
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      drain_results();
      test_small_images();
      drain_results();
      test_palette_overflow();
      drain_results();

      // anything still in flight would show up as an unexpected strobe
      repeat (DRAIN_WAIT) @(posedge clock);
      if (reduced_q.size() != 0) begin
         $error("%0d results never arrived", reduced_q.size());
         mismatches++;
      end

      $display("run: %0d pixel transfers, %0d results checked, %0d mismatches",
               n_sent, n_checked, mismatches);
      $display("run: %0d palette appends, %0d lookup misses, %0d palette overflows",
               n_appends, n_misses, n_overflows);
      if (mismatches == 0) begin
         $display("tb_png_color_type_reducer_core: clean");
      end else begin
         $display("tb_png_color_type_reducer_core: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/pctr_pkg.sv
rtl/core/pctr_cell.sv
rtl/core/png_color_type_reducer_core.sv
bench/tb_png_color_type_reducer_core.sv
